### rtl/core/sorted_list_insert_remove_assert.svh
// ----------------------------------------------------------------------------
// sorted list assertion macros
// concurrent assertion shorthands clocked by clk and gated by rst
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_ASSERT_SVH

// same-cycle implication
`define SLI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// shared types, codes and sizes of the sorted key table
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int COUNT_W  = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] STAT_DONE      = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_ENTRY     = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic [4:0]         stored_count;
    logic               last;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic noop;
    logic last;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/sorted_list_insert_remove.sv
// insert and remove: the request is registered on take, the result on execute,
//   and it is shown in the deliver state; a new request is taken only once the
//   result is accepted; all cells compare and shift in the execute cycle
// dump: first key on deliver, then one key per unstalled cycle, largest first
// reset: synchronous, empties the table; key cells hold no reset value
// ----------------------------------------------------------------------------
// sorted_list_insert_remove
// sorted signed key table with insert, remove and descending dump
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_remove import sli_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sli_datapath u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

`include "sorted_list_insert_remove_assert.svh"

  `SLI_ASSERT_NOW(a_count_range, rsp_valid, rsp.stored_count <= COUNT_W'(CAPACITY), "count above capacity")
  `SLI_ASSERT_NOW(a_one_at_a_time, rsp_valid, req_stall, "request taken while results pending")
  `SLI_ASSERT_NEXT(a_exec_gap, req_valid && !req_stall, !rsp_valid, "result before execute")
  `SLI_ASSERT_NOW(a_not_last_is_entry, rsp_valid && !rsp.last, rsp.status == STAT_ENTRY, "bad status")

endmodule

`default_nettype wire

### rtl/core/sli_datapath.sv
// ----------------------------------------------------------------------------
// sli_datapath
// key cell chain with per-cell compare, key count, dump index and result
// register
// ----------------------------------------------------------------------------
`default_nettype none

module sli_datapath import sli_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output rsp_t      rsp
);

  logic [1:0]           req_op;
  key_t                 req_key;
  key_t                 cells [CAPACITY];
  key_t                 ins [CAPACITY];
  key_t                 rem [CAPACITY];
  logic [CNT_W-1:0]     count;
  logic [IDX_W-1:0]     idx;
  logic [IDX_W-1:0]     rd_idx;
  logic [IDX_W-1:0]     top_idx;
  logic [CNT_W-1:0]     count_m1;
  logic [CAPACITY-1:0]  live;
  logic [CAPACITY-1:0]  le;
  logic [CAPACITY-1:0]  eq;
  logic [CAPACITY-1:0]  seen;
  logic                 full;
  key_t                 rd_key;
  rsp_t                 rsp_r;

  // per-cell compares and shift sources
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live[i] = CNT_W'(i) < count;
      le[i]   = live[i] && (cells[i] <= req_key);
      eq[i]   = live[i] && (cells[i] == req_key);
    end
    seen[0] = eq[0];
    for (int i = 1; i < CAPACITY; i++) begin
      seen[i] = seen[i-1] | eq[i];
    end
    ins[0] = le[0] ? cells[0] : req_key;
    for (int i = 1; i < CAPACITY; i++) begin
      if (le[i]) begin
        ins[i] = cells[i];
      end else if (le[i-1]) begin
        ins[i] = req_key;
      end else begin
        ins[i] = cells[i-1];
      end
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      rem[i] = seen[i] ? cells[i+1] : cells[i];
    end
    rem[CAPACITY-1] = cells[CAPACITY-1];
  end

  assign full     = (count == CNT_W'(CAPACITY));
  assign count_m1 = CNT_W'(count - CNT_W'(1));
  assign top_idx  = count_m1[IDX_W-1:0];
  assign rd_idx   = cmd.exec ? top_idx : IDX_W'(idx - IDX_W'(1));
  assign rd_key   = cells[rd_idx];

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else if (cmd.exec) begin
      case (req_op)
        OP_INSERT: begin
          if (!full) begin
            count <= CNT_W'(count + CNT_W'(1));
          end
        end
        OP_REMOVE: begin
          if (seen[CAPACITY-1]) begin
            count <= count_m1;
          end
        end
        OP_DUMP: begin
          idx <= top_idx;
        end
        default: begin
        end
      endcase
    end else if (cmd.step) begin
      idx <= rd_idx;
    end
  end

  // request, cells and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op  <= req.op;
      req_key <= req.key;
    end
    if (cmd.exec) begin
      case (req_op)
        OP_INSERT: begin
          if (full) begin
            rsp_r <= '{STAT_FULL, req_key, COUNT_W'(count), 1'b1};
          end else begin
            cells <= ins;
            rsp_r <= '{STAT_DONE, req_key, COUNT_W'(count + CNT_W'(1)), 1'b1};
          end
        end
        OP_REMOVE: begin
          if (seen[CAPACITY-1]) begin
            cells <= rem;
            rsp_r <= '{STAT_DONE, req_key, COUNT_W'(count_m1), 1'b1};
          end else begin
            rsp_r <= '{STAT_NOT_FOUND, req_key, COUNT_W'(count), 1'b1};
          end
        end
        OP_DUMP: begin
          if (count == '0) begin
            rsp_r <= '{STAT_EMPTY, '0, '0, 1'b1};
          end else begin
            rsp_r <= '{STAT_ENTRY, rd_key, COUNT_W'(count), count == CNT_W'(1)};
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.step) begin
      rsp_r <= '{STAT_ENTRY, rd_key, COUNT_W'(count), idx == IDX_W'(1)};
    end
  end

  assign sts.noop = (req_op == OP_NONE);
  assign sts.last = rsp_r.last;
  assign rsp      = rsp_r;

endmodule

`default_nettype wire

### rtl/core/sli_ctrl.sv
// ----------------------------------------------------------------------------
// sli_ctrl
// request sequencer: take, execute, deliver results
// ----------------------------------------------------------------------------
`default_nettype none

module sli_ctrl import sli_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    rsp_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.noop ? S_IDLE : S_OUT;
      end
      S_OUT: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          if (sts.last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
